/* rtl/qlj_pkg.sv */
// Shared types, constants and rounding helpers of the quadrotor Jacobian block.
`default_nettype none
package qlj_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QW            = 24;
	localparam int DIV_W         = 62;
	localparam int DW            = 66;

	typedef struct packed {
		logic signed [QW-1:0] qw;
		logic signed [QW-1:0] qx;
		logic signed [QW-1:0] qy;
		logic signed [QW-1:0] qz;
		logic signed [QW-1:0] rx;
		logic signed [QW-1:0] ry;
		logic signed [QW-1:0] rz;
		logic signed [QW-1:0] thr;
	} in_item_t;

	// item after norm, root and unit quaternion are known
	typedef struct packed {
		in_item_t        d;
		logic [31:0]     m;
		logic [3:0][31:0] u;
		logic            zero;
	} prep_t;

	// round to nearest on the magnitude, ties away from zero
	function automatic logic signed [DW-1:0] rnd_shr(input logic signed [DW-1:0] v,
		input int s);
		logic [DW-1:0] mag;
		mag = v[DW-1] ? DW'(-v) : DW'(v);
		mag = (mag + (DW'(1) << (s - 1))) >> s;
		return v[DW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [DW-1:0] v);
		logic [31:0] r;
		if (v > $signed(DW'(32'h7FFF_FFFF)))
			r = 32'h7FFF_FFFF;
		else if (v < -$signed(DW'(33'h0_8000_0000)))
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/quadrotor_linearization_jacobian_top.sv */
// Top level of the quadrotor linearized-dynamics Jacobian block.
//
// Input channel: a queue write port (push/full). One item is a quaternion
// w,x,y,z, three body rates and a normalized thrust, all signed 24 bit with
// FRAC_BITS fraction bits. An item is taken when push is high and full low.
// Result channel: a queue read port (empty/pop). Each item yields 46 results:
// the nonzero entries of A (10x10) row-major, then of B (10x4) row-major,
// each with matrix_select, row_index, col_index, a saturated Q16.16 value,
// norm_error (zero quaternion) and last_entry on the 46th.
// The front end finds |q| by a 32-step square root and the unit quaternion
// by four serial divisions. A two-deep item queue lets it run up to two
// items ahead of the back end, and an input holding register takes one
// more item while the front end is busy. The back end runs one serial
// division for each of the 28 attitude and velocity entries of A (none
// for a zero quaternion); that divider sets the sustained rate. When pop
// stays low the result register holds, the back end stops, and the queues
// fill until full rises. Reset empties all queues; no result is pending
// afterwards.
`default_nettype none
module quadrotor_linearization_jacobian_top
	import qlj_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [23:0] quat_w,
	input  wire logic signed [23:0] quat_x,
	input  wire logic signed [23:0] quat_y,
	input  wire logic signed [23:0] quat_z,
	input  wire logic signed [23:0] rate_x,
	input  wire logic signed [23:0] rate_y,
	input  wire logic signed [23:0] rate_z,
	input  wire logic signed [23:0] thrust_accel,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    matrix_select,
	output logic [3:0]              row_index,
	output logic [3:0]              col_index,
	output logic signed [31:0]      entry_value,
	output logic                    norm_error,
	output logic                    last_entry
);
	in_item_t   in_item;
	logic       fq_push;
	prep_t      fq_wdata;
	logic       fq_full;
	logic       fq_valid;
	logic       fq_pop;
	prep_t      fq_mem_q [2];
	logic       fq_wr_q;
	logic       fq_rd_q;
	logic [1:0] fq_cnt_q;
	logic       out_valid;
	logic [31:0] value_bits;

	assign in_item = '{qw: quat_w, qx: quat_x, qy: quat_y, qz: quat_z,
		rx: rate_x, ry: rate_y, rz: rate_z, thr: thrust_accel};

	qlj_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.in_item(in_item),
		.fq_push(fq_push),
		.fq_item(fq_wdata),
		.fq_full(fq_full)
	);

	// two-deep item queue between front and back end
	assign fq_full  = fq_cnt_q == 2'd2;
	assign fq_valid = fq_cnt_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fq_wr_q  <= 1'b0;
			fq_rd_q  <= 1'b0;
			fq_cnt_q <= '0;
		end else begin
			if (fq_push)
				fq_wr_q <= !fq_wr_q;
			if (fq_pop)
				fq_rd_q <= !fq_rd_q;
			if (fq_push && !fq_pop)
				fq_cnt_q <= fq_cnt_q + 2'd1;
			else if (fq_pop && !fq_push)
				fq_cnt_q <= fq_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fq_push)
			fq_mem_q[fq_wr_q] <= fq_wdata;
	end

	qlj_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fq_valid     (fq_valid),
		.fq_item      (fq_mem_q[fq_rd_q]),
		.fq_pop       (fq_pop),
		.out_valid    (out_valid),
		.out_pop      (pop),
		.matrix_select(matrix_select),
		.row_index    (row_index),
		.col_index    (col_index),
		.entry_value  (value_bits),
		.norm_error   (norm_error),
		.last_entry   (last_entry)
	);

	assign entry_value = $signed(value_bits);
	assign empty       = !out_valid;

	a_fq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |-> !fq_full)
		else $error("item queue written while full");

	a_zero_norm_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && norm_error && !matrix_select && row_index >= 4'd3)
		|-> (entry_value == 32'sd0))
		else $error("zero quaternion gave nonzero attitude or velocity entry");

	a_last_place: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_entry) |-> (matrix_select && row_index == 4'd9 && col_index == 4'd3))
		else $error("last entry flagged at wrong position");
endmodule
`default_nettype wire

/* rtl/qlj_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module qlj_div
	import qlj_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [31:0]      den,
	output logic                  done,
	output logic [DIV_W-1:0]      quo
);
	logic [DIV_W-1:0] num_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      sh;
	logic             ge;

	assign sh   = {rem_q, num_q[DIV_W-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign done = done_q;
	assign quo  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(sh - {1'b0, den_q}) : sh[31:0];
			num_q <= {num_q[DIV_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

/* rtl/qlj_front.sv */
// Front end: takes items, finds the norm root and the unit quaternion.
`default_nettype none
module qlj_front
	import qlj_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t in_item,
	output logic          fq_push,
	output prep_t         fq_item,
	input  wire logic     fq_full
);
	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_MUL  = 7'b0000010,
		F_ACC  = 7'b0000100,
		F_SQI  = 7'b0001000,
		F_SQRT = 7'b0010000,
		F_DIVS = 7'b0100000,
		F_DIVW = 7'b1000000
	} fstate_t;

	fstate_t          state_q;
	in_item_t         hold_q;
	logic             hold_valid_q;
	prep_t            it_q;
	logic             push_q;
	logic [1:0]       c_q;
	logic [48:0]      n2_q;
	logic [47:0]      prod_q;
	logic [63:0]      rad_q;
	logic [34:0]      rem_q;
	logic [31:0]      root_q;
	logic [4:0]       cnt_q;
	logic signed [QW-1:0] qc;
	logic [QW-1:0]    qmag;
	logic [34:0]      rem_n;
	logic [34:0]      trial;
	logic             sq_ge;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	assign full    = hold_valid_q;
	assign fq_item = it_q;
	assign fq_push = push_q && !fq_full;

	always_comb begin
		unique case (c_q)
			2'd0: qc = it_q.d.qw;
			2'd1: qc = it_q.d.qx;
			2'd2: qc = it_q.d.qy;
			default: qc = it_q.d.qz;
		endcase
	end

	assign qmag      = qc[QW-1] ? QW'(-qc) : QW'(qc);
	assign rem_n     = {rem_q[32:0], rad_q[63:62]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign sq_ge     = rem_n >= trial;
	assign div_start = state_q == F_DIVS;
	assign div_num   = DIV_W'({qmag, 37'd0}) + DIV_W'(it_q.m >> 1);

	qlj_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (it_q.m),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			hold_valid_q <= 1'b0;
			push_q       <= 1'b0;
			c_q          <= '0;
			cnt_q        <= '0;
		end else begin
			if (fq_push)
				push_q <= 1'b0;
			if (push && !hold_valid_q)
				hold_valid_q <= 1'b1;
			unique case (state_q)
				F_IDLE: begin
					if (hold_valid_q && !push_q) begin
						hold_valid_q <= 1'b0;
						c_q          <= '0;
						state_q      <= F_MUL;
					end
				end
				F_MUL: state_q <= F_ACC;
				F_ACC: begin
					c_q <= c_q + 2'd1;
					state_q <= (c_q == 2'd3) ? F_SQI : F_MUL;
				end
				F_SQI: begin
					cnt_q <= '0;
					if (n2_q == '0) begin
						push_q  <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_SQRT;
					end
				end
				F_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						c_q     <= '0;
						state_q <= F_DIVS;
					end
				end
				F_DIVS: state_q <= F_DIVW;
				F_DIVW: begin
					if (div_done) begin
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3) begin
							push_q  <= 1'b1;
							state_q <= F_IDLE;
						end else begin
							state_q <= F_DIVS;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !hold_valid_q)
			hold_q <= in_item;
		unique case (state_q)
			F_IDLE: begin
				if (hold_valid_q && !push_q) begin
					it_q.d <= hold_q;
					n2_q   <= '0;
				end
			end
			F_MUL: prod_q <= 48'(qc * qc);
			F_ACC: n2_q <= n2_q + 49'(prod_q);
			F_SQI: begin
				it_q.zero <= n2_q == '0;
				it_q.m    <= '0;
				it_q.u    <= '0;
				rad_q     <= {1'b0, n2_q, 14'd0};
				rem_q     <= '0;
				root_q    <= '0;
			end
			F_SQRT: begin
				rad_q  <= {rad_q[61:0], 2'b00};
				rem_q  <= sq_ge ? 35'(rem_n - trial) : rem_n;
				root_q <= {root_q[30:0], sq_ge};
				if (cnt_q == 5'd31)
					it_q.m <= {root_q[30:0], sq_ge};
			end
			F_DIVW: begin
				if (div_done)
					it_q.u[c_q] <= qc[QW-1] ? 32'(-div_quo[31:0]) : div_quo[31:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/qlj_back.sv */
// Back end: walks the 46 nonzero entries of A and B for one prepared item.
`default_nettype none
module qlj_back
	import qlj_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fq_valid,
	input  wire prep_t  fq_item,
	output logic        fq_pop,
	output logic        out_valid,
	input  wire logic   out_pop,
	output logic        matrix_select,
	output logic [3:0]  row_index,
	output logic [3:0]  col_index,
	output logic [31:0] entry_value,
	output logic        norm_error,
	output logic        last_entry
);
	localparam int SH_Q = FRAC_BITS + 6;

	typedef enum logic [10:0] {
		B_IDLE  = 11'b00000000001,
		B_START = 11'b00000000010,
		B_MUL   = 11'b00000000100,
		B_ACC   = 11'b00000001000,
		B_RED   = 11'b00000010000,
		B_WU    = 11'b00000100000,
		B_T     = 11'b00001000000,
		B_TM    = 11'b00010000000,
		B_DS    = 11'b00100000000,
		B_DIV   = 11'b01000000000,
		B_OUT   = 11'b10000000000
	} bstate_t;

	typedef enum logic [2:0] {K_POS, K_AQ, K_AV, K_BQ, K_BT} kind_t;

	function automatic logic signed [32:0] quat_coef(input logic [1:0] i,
		input logic [1:0] c, input in_item_t d);
		logic signed [32:0] x, y, z;
		logic signed [32:0] r [4];
		x = 33'(d.rx);
		y = 33'(d.ry);
		z = 33'(d.rz);
		unique case (i)
			2'd0: r = '{33'sd0, -x, -y, -z};
			2'd1: r = '{x, 33'sd0, z, -y};
			2'd2: r = '{y, -z, 33'sd0, x};
			default: r = '{z, y, -x, 33'sd0};
		endcase
		return r[c];
	endfunction

	function automatic logic signed [32:0] vel_coef(input logic [1:0] i,
		input logic [1:0] c, input in_item_t d);
		logic signed [32:0] w, x, y, z;
		logic signed [32:0] r [4];
		w = 33'(d.qw);
		x = 33'(d.qx);
		y = 33'(d.qy);
		z = 33'(d.qz);
		unique case (i)
			2'd0: r = '{y, z, w, x};
			2'd1: r = '{-x, -w, z, y};
			default: r = '{w, -x, -y, z};
		endcase
		return r[c];
	endfunction

	function automatic logic signed [32:0] bq_coef(input logic [1:0] i,
		input logic [1:0] j, input in_item_t d);
		logic signed [32:0] w, x, y, z;
		logic signed [32:0] r [4];
		w = 33'(d.qw);
		x = 33'(d.qx);
		y = 33'(d.qy);
		z = 33'(d.qz);
		unique case (i)
			2'd0: r = '{-x, -y, -z, 33'sd0};
			2'd1: r = '{w, -z, y, 33'sd0};
			2'd2: r = '{z, w, -x, 33'sd0};
			default: r = '{-y, x, w, 33'sd0};
		endcase
		return r[j];
	endfunction

	bstate_t            state_q;
	prep_t              it_q;
	logic               sel_q;
	logic [3:0]         row_q;
	logic [3:0]         col_q;
	logic [1:0]         c_q;
	logic signed [DW-1:0] acc_q;
	logic signed [DW-1:0] prod_q;
	logic signed [DW-1:0] wi_q;
	logic signed [DW-1:0] t_q;
	logic signed [DW-1:0] val_q;
	logic               sign_q;
	logic               out_valid_q;
	logic               sel_o_q;
	logic [3:0]         row_o_q;
	logic [3:0]         col_o_q;
	logic [31:0]        val_o_q;
	logic               err_o_q;
	logic               last_o_q;

	kind_t              kind;
	logic [3:0]         ri4, rv4, cj4;
	logic [1:0]         ri, rv, cj;
	logic signed [32:0] mul_a, mul_b;
	logic signed [DW-1:0] prod_n;
	logic signed [32:0] coef_j;
	logic signed [DW-1:0] t_n;
	logic [DW-1:0]      t_mag, p_mag;
	logic [DIV_W-1:0]   div_num;
	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic               is_last;
	logic               nsel;
	logic [3:0]         nrow, ncol;
	logic               out_load;

	assign ri4 = row_q - 4'd3;
	assign rv4 = row_q - 4'd7;
	assign cj4 = col_q - 4'd3;
	assign ri  = ri4[1:0];
	assign rv  = rv4[1:0];
	assign cj  = cj4[1:0];

	always_comb begin
		priority if (!sel_q && row_q < 4'd3) kind = K_POS;
		else if (!sel_q && row_q < 4'd7)     kind = K_AQ;
		else if (!sel_q)                     kind = K_AV;
		else if (row_q < 4'd7)               kind = K_BQ;
		else                                 kind = K_BT;
	end

	function automatic logic signed [32:0] u_at(input prep_t p, input logic [1:0] k);
		return 33'($signed(p.u[k]));
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (state_q == B_MUL) begin
			priority if (kind == K_AQ) begin
				mul_a = quat_coef(ri, c_q, it_q.d);
				mul_b = u_at(it_q, c_q);
			end else if (kind == K_AV) begin
				mul_a = vel_coef(rv, c_q, it_q.d);
				mul_b = u_at(it_q, c_q);
			end else if (row_q == 4'd7) begin
				// 2(wy + xz)
				mul_a = (c_q == 2'd0) ? 33'(it_q.d.qw) : (c_q == 2'd1) ? 33'(it_q.d.qx) : '0;
				mul_b = (c_q == 2'd0) ? 33'(it_q.d.qy) : 33'(it_q.d.qz);
			end else if (row_q == 4'd8) begin
				// 2(yz - wx)
				mul_a = (c_q == 2'd0) ? 33'(it_q.d.qy) : (c_q == 2'd1) ? -33'(it_q.d.qw) : '0;
				mul_b = (c_q == 2'd0) ? 33'(it_q.d.qz) : 33'(it_q.d.qx);
			end else begin
				// w^2 - x^2 - y^2 + z^2
				unique case (c_q)
					2'd0: begin mul_a = 33'(it_q.d.qw);  mul_b = 33'(it_q.d.qw); end
					2'd1: begin mul_a = -33'(it_q.d.qx); mul_b = 33'(it_q.d.qx); end
					2'd2: begin mul_a = -33'(it_q.d.qy); mul_b = 33'(it_q.d.qy); end
					default: begin mul_a = 33'(it_q.d.qz); mul_b = 33'(it_q.d.qz); end
				endcase
			end
		end else if (state_q == B_WU) begin
			mul_a = wi_q[32:0];
			mul_b = u_at(it_q, cj);
		end else if (state_q == B_TM) begin
			mul_a = t_q[32:0];
			mul_b = 33'(it_q.d.thr);
		end else begin
			mul_a = '0;
			mul_b = '0;
		end
	end

	assign prod_n  = DW'(mul_a) * DW'(mul_b);
	assign coef_j  = (kind == K_AQ) ? quat_coef(ri, cj, it_q.d) : vel_coef(rv, cj, it_q.d);
	assign t_n     = DW'(coef_j) - rnd_shr(prod_q, 30);
	assign t_mag   = t_q[DW-1] ? DW'(-t_q) : DW'(t_q);
	assign p_mag   = prod_q[DW-1] ? DW'(-prod_q) : DW'(prod_q);
	assign div_num = ((kind == K_AQ) ? DIV_W'(t_mag << SH_Q) : DIV_W'(p_mag << 8))
		+ DIV_W'(it_q.m >> 1);
	assign div_start = state_q == B_DS;

	qlj_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (it_q.m),
		.done  (div_done),
		.quo   (div_quo)
	);

	// entry walk: A position, A quaternion, A velocity, B rate, B thrust
	always_comb begin
		nsel    = sel_q;
		nrow    = row_q;
		ncol    = col_q;
		is_last = sel_q && row_q == 4'd9;
		if (!sel_q) begin
			if (row_q < 4'd3) begin
				nrow = row_q + 4'd1;
				ncol = (row_q == 4'd2) ? 4'd3 : row_q + 4'd8;
			end else if (col_q < 4'd6) begin
				ncol = col_q + 4'd1;
			end else if (row_q == 4'd9) begin
				nsel = 1'b1;
				nrow = 4'd3;
				ncol = 4'd0;
			end else begin
				nrow = row_q + 4'd1;
				ncol = 4'd3;
			end
		end else if (row_q < 4'd7) begin
			if (col_q < 4'd2) begin
				ncol = col_q + 4'd1;
			end else begin
				nrow = row_q + 4'd1;
				ncol = (row_q == 4'd6) ? 4'd3 : 4'd0;
			end
		end else begin
			nrow = row_q + 4'd1;
		end
	end

	assign out_load  = state_q == B_OUT && (!out_valid_q || out_pop);
	assign fq_pop    = state_q == B_IDLE && fq_valid;
	assign out_valid = out_valid_q;
	assign matrix_select = sel_o_q;
	assign row_index     = row_o_q;
	assign col_index     = col_o_q;
	assign entry_value   = val_o_q;
	assign norm_error    = err_o_q;
	assign last_entry    = last_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			c_q         <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (fq_valid) begin
						sel_q   <= 1'b0;
						row_q   <= 4'd0;
						col_q   <= 4'd7;
						state_q <= B_START;
					end
				end
				B_START: begin
					c_q <= '0;
					priority if (kind == K_POS || kind == K_BQ)
						state_q <= B_OUT;
					else if (kind != K_BT && it_q.zero)
						state_q <= B_OUT;
					else
						state_q <= B_MUL;
				end
				B_MUL: state_q <= B_ACC;
				B_ACC: begin
					c_q <= c_q + 2'd1;
					state_q <= (c_q == 2'd3) ? B_RED : B_MUL;
				end
				B_RED: state_q <= (kind == K_BT) ? B_OUT : B_WU;
				B_WU:  state_q <= B_T;
				B_T:   state_q <= (kind == K_AQ) ? B_DS : B_TM;
				B_TM:  state_q <= B_DS;
				B_DS:  state_q <= B_DIV;
				B_DIV: begin
					if (div_done)
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_load) begin
						sel_q <= nsel;
						row_q <= nrow;
						col_q <= ncol;
						state_q <= is_last ? B_IDLE : B_START;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop)
			it_q <= fq_item;
		unique case (state_q)
			B_START: begin
				acc_q <= '0;
				priority if (kind == K_POS)
					val_q <= DW'(1) << FRAC_BITS;
				else if (kind == K_BQ)
					val_q <= rnd_shr(DW'(bq_coef(ri, col_q[1:0], it_q.d)), 1);
				else
					val_q <= '0;
			end
			B_MUL: prod_q <= prod_n;
			B_ACC: acc_q <= acc_q + prod_q;
			B_RED: begin
				if (kind == K_BT)
					val_q <= rnd_shr((row_q == 4'd9) ? acc_q : (acc_q <<< 1), FRAC_BITS);
				else
					wi_q <= rnd_shr(acc_q, 30);
			end
			B_WU: prod_q <= prod_n;
			B_T:  t_q <= t_n;
			B_TM: prod_q <= prod_n;
			B_DS: sign_q <= (kind == K_AQ) ? t_q[DW-1] : prod_q[DW-1];
			B_DIV: begin
				if (div_done)
					val_q <= sign_q ? -$signed(DW'(div_quo)) : $signed(DW'(div_quo));
			end
			default: ;
		endcase
		if (out_load) begin
			sel_o_q  <= sel_q;
			row_o_q  <= row_q;
			col_o_q  <= col_q;
			val_o_q  <= sat32(val_q);
			err_o_q  <= it_q.zero;
			last_o_q <= is_last;
		end
	end
endmodule
`default_nettype wire
